// ===== src/hds_pkg.sv =====
// shared types, constants and helpers of the heat diffusion stencil engine
package hds_pkg;

    // grid store geometry
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int ADDR_W    = $clog2(CELLS);

    // field widths
    localparam int OP_W      = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 7;
    localparam int COEF_W    = 16;
    localparam int STEP_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    // comparison width wide enough for any index or dimension
    localparam int CNT_W = ((ADDR_W > DIM_W) ? ADDR_W : DIM_W) + 1;

    // stream widths
    localparam int IN_DATA_W   = ((ROW_W + COL_W + DATA_W + 7) / 8) * 8;
    localparam int IN_USER_W   = OP_W;
    localparam int OUT_DATA_W  = DATA_W;
    localparam int OUT_USER_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CX_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CY_COEF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY  = 3'd5;

    // register reset values
    localparam logic [DIM_W-1:0]  RST_GRID_ROWS = 7'd64;
    localparam logic [DIM_W-1:0]  RST_GRID_COLS = 7'd64;
    localparam logic [COEF_W-1:0] RST_CX_COEF   = 16'd0;
    localparam logic [COEF_W-1:0] RST_CY_COEF   = 16'd0;
    localparam logic [STEP_W-1:0] RST_STEPS     = 16'd17;
    localparam logic [DATA_W-1:0] RST_BOUNDARY  = 32'h0001_0000;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // which neighbor a stencil read fetches
    typedef enum logic [2:0] {
        TAP_C = 3'd0,
        TAP_W = 3'd1,
        TAP_E = 3'd2,
        TAP_N = 3'd3,
        TAP_S = 3'd4
    } t_tap;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_SWEEP = 3'd2,
        ST_DRAIN = 3'd3,
        ST_EDGE  = 3'd4,
        ST_DONE  = 3'd5
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0]  grid_rows;
        logic [DIM_W-1:0]  grid_cols;
        logic [COEF_W-1:0] cx_coef;
        logic [COEF_W-1:0] cy_coef;
        logic [STEP_W-1:0] step_count;
        logic [DATA_W-1:0] boundary_value;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_item;

    // stencil read tag, travels alongside the memory read
    typedef struct packed {
        logic              valid;
        t_tap              tap;
        logic [ADDR_W-1:0] addr;
    } t_issue;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (int'(v) < 3) begin
            return DIM_W'(3);
        end else if (int'(v) > hi) begin
            return DIM_W'(hi);
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] r,
                                                    input logic [COL_IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

endpackage

// ===== src/hds_ram.sv =====
// generic single-write, single-read memory with registered read data
module hds_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hds_stencil.sv =====
// five-point stencil datapath: gathers neighbors, multiplies, rounds and saturates
module hds_stencil (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hds_pkg::COEF_W-1:0]    i_cx,
    input  logic [hds_pkg::COEF_W-1:0]    i_cy,
    input  hds_pkg::t_issue               i_issue,
    input  logic [hds_pkg::DATA_W-1:0]    i_rd_data,
    output hds_pkg::t_wr                  o_wr,
    output logic                          o_busy
);
    import hds_pkg::*;

    localparam int DX_W   = DATA_W + 2;
    localparam int PROD_W = DX_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int HALF   = 1 << (FRAC_W - 1);

    // tag of the read in flight
    logic              r_tag_v;
    t_tap              r_tag_tap;
    logic [ADDR_W-1:0] r_tag_addr;

    // gathered neighbors
    logic signed [DATA_W-1:0] r_c, r_w, r_e, r_n;
    logic signed [DATA_W-1:0] w_rd;

    // stage 1: second differences
    logic                     r_s1_v;
    logic signed [DATA_W-1:0] r_s1_c;
    logic signed [DX_W-1:0]   r_s1_dx, r_s1_dy;
    logic [ADDR_W-1:0]        r_s1_addr;

    // stage 2: products
    logic                     r_s2_v;
    logic signed [DATA_W-1:0] r_s2_c;
    logic signed [PROD_W-1:0] r_s2_px, r_s2_py;
    logic [ADDR_W-1:0]        r_s2_addr;

    // stage 3: rounded sum
    logic                     r_s3_v;
    logic signed [SUM_W-1:0]  r_s3_sum;
    logic [ADDR_W-1:0]        r_s3_addr;

    logic [SUM_W-FRAC_W-DATA_W:0] w_hi;
    logic [DATA_W-1:0]            w_sat;

    assign w_rd = i_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_v <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
        end else begin
            r_tag_v <= i_issue.valid;
            r_s1_v  <= r_tag_v && (r_tag_tap == TAP_S);
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_tap  <= i_issue.tap;
        r_tag_addr <= i_issue.addr;
        if (r_tag_v) begin
            case (r_tag_tap)
                TAP_C: r_c <= w_rd;
                TAP_W: r_w <= w_rd;
                TAP_E: r_e <= w_rd;
                TAP_N: r_n <= w_rd;
                default: begin
                end
            endcase
        end
        // south neighbor arrives last, straight from memory
        r_s1_c    <= r_c;
        r_s1_dx   <= DX_W'(r_w) + DX_W'(r_e) - (DX_W'(r_c) <<< 1);
        r_s1_dy   <= DX_W'(r_n) + DX_W'(w_rd) - (DX_W'(r_c) <<< 1);
        r_s1_addr <= r_tag_addr;

        r_s2_c    <= r_s1_c;
        r_s2_px   <= $signed({1'b0, i_cx}) * r_s1_dx;
        r_s2_py   <= $signed({1'b0, i_cy}) * r_s1_dy;
        r_s2_addr <= r_s1_addr;

        r_s3_sum  <= (SUM_W'(r_s2_c) <<< FRAC_W) + SUM_W'(r_s2_px) + SUM_W'(r_s2_py)
                   + SUM_W'(HALF);
        r_s3_addr <= r_s2_addr;
    end

    // floor shift is the upper slice; saturate when it does not fit 32 bits
    assign w_hi = r_s3_sum[SUM_W-1:FRAC_W+DATA_W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = r_s3_sum[FRAC_W+DATA_W-1:FRAC_W];
        end else if (w_hi[$high(w_hi)]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_wr.valid = r_s3_v;
    assign o_wr.addr  = r_s3_addr;
    assign o_wr.data  = w_sat;
    assign o_busy     = r_tag_v | r_s1_v | r_s2_v | r_s3_v;

endmodule

// ===== src/hds_ctrl.sv =====
// sequencer: host access, sweep and edge walks, bank routing, result register
module hds_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hds_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hds_pkg::t_item                i_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hds_pkg::DATA_W-1:0]    o_out_value,
    output logic                          o_out_done,
    input  logic [hds_pkg::DATA_W-1:0]    i_q_a,
    input  logic [hds_pkg::DATA_W-1:0]    i_q_b,
    output hds_pkg::t_mem_req             o_req_a,
    output hds_pkg::t_mem_req             o_req_b,
    output logic [hds_pkg::DATA_W-1:0]    o_rd_data,
    output hds_pkg::t_issue               o_issue,
    input  logic                          i_busy,
    input  hds_pkg::t_wr                  i_wr
);
    import hds_pkg::*;

    t_state               r_state, n_state;
    logic                 r_cur, n_cur;
    logic [ROW_IDX_W-1:0] r_i, n_i;
    logic [COL_IDX_W-1:0] r_j, n_j;
    t_tap                 r_tap, n_tap;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic                 r_rd_bank, n_rd_bank;
    logic                 r_rd_ok, n_rd_ok;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_value;
    logic                 r_out_done;

    logic                 w_accept;
    t_op                  w_op;
    logic                 w_in_range;
    logic [ADDR_W-1:0]    w_host_addr;
    logic [ADDR_W-1:0]    w_center;
    logic [DIM_W-1:0]     w_rows, w_cols;
    logic [CNT_W-1:0]     w_rows_m1, w_rows_m2, w_cols_m1, w_cols_m2;
    logic [CNT_W-1:0]     w_i, w_j;
    logic                 w_sw_last_j, w_sw_last;
    logic                 w_edge_row, w_edge_last_j, w_edge_last;

    // memory access of this cycle before bank routing
    logic                 w_we, w_wbank, w_re;
    logic [ADDR_W-1:0]    w_waddr, w_raddr;
    logic [DATA_W-1:0]    w_wdata;

    // result load
    logic                 w_load;
    logic [DATA_W-1:0]    w_load_value;
    logic                 w_load_done;

    assign w_rows    = clamp_dim(i_cfg.grid_rows, MAX_ROWS);
    assign w_cols    = clamp_dim(i_cfg.grid_cols, MAX_COLS);
    assign w_rows_m1 = CNT_W'(w_rows) - CNT_W'(1);
    assign w_rows_m2 = CNT_W'(w_rows) - CNT_W'(2);
    assign w_cols_m1 = CNT_W'(w_cols) - CNT_W'(1);
    assign w_cols_m2 = CNT_W'(w_cols) - CNT_W'(2);
    assign w_i       = CNT_W'(r_i);
    assign w_j       = CNT_W'(r_j);

    assign w_sw_last_j   = (w_j == w_cols_m2);
    assign w_sw_last     = w_sw_last_j && (w_i == w_rows_m2);
    assign w_edge_row    = (w_i == '0) || (w_i == w_rows_m1);
    assign w_edge_last_j = (w_j == w_cols_m1);
    assign w_edge_last   = w_edge_last_j && (w_i == w_rows_m1);

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op       = t_op'(i_item.operation);
    assign w_in_range = (CNT_W'(i_item.row) < CNT_W'(MAX_ROWS))
                     && (CNT_W'(i_item.col) < CNT_W'(MAX_COLS));
    assign w_host_addr = cell_addr(ROW_IDX_W'(i_item.row), COL_IDX_W'(i_item.col));
    assign w_center    = cell_addr(r_i, r_j);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_RUN:  n_state = (i_cfg.step_count == '0) ? ST_DONE : ST_SWEEP;
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_IDLE;
            ST_SWEEP: begin
                if ((r_tap == TAP_S) && w_sw_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_busy) begin
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: begin
                if (w_edge_last) begin
                    n_state = (r_steps == STEP_W'(1)) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        n_cur        = r_cur;
        n_i          = r_i;
        n_j          = r_j;
        n_tap        = r_tap;
        n_steps      = r_steps;
        n_rd_bank    = r_rd_bank;
        n_rd_ok      = r_rd_ok;
        w_we         = 1'b0;
        w_wbank      = ~r_cur;
        w_waddr      = i_wr.addr;
        w_wdata      = i_wr.data;
        w_re         = 1'b0;
        w_raddr      = w_host_addr;
        o_issue      = '0;
        w_load       = 1'b0;
        w_load_value = '0;
        w_load_done  = 1'b0;

        // stencil results land in the destination bank
        if (i_wr.valid) begin
            w_we = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_WRITE: begin
                            w_we    = w_in_range;
                            w_wbank = r_cur;
                            w_waddr = w_host_addr;
                            w_wdata = i_item.value;
                            w_load  = 1'b1;
                        end
                        OP_RUN: begin
                            n_steps = i_cfg.step_count;
                            n_i     = ROW_IDX_W'(1);
                            n_j     = COL_IDX_W'(1);
                            n_tap   = TAP_C;
                        end
                        OP_READ: begin
                            w_re      = 1'b1;
                            n_rd_bank = r_cur;
                            n_rd_ok   = w_in_range;
                        end
                        default: w_load = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                w_load       = 1'b1;
                w_load_value = r_rd_ok ? o_rd_data : '0;
            end
            ST_SWEEP: begin
                w_re          = 1'b1;
                n_rd_bank     = r_cur;
                o_issue.valid = 1'b1;
                o_issue.tap   = r_tap;
                o_issue.addr  = w_center;
                case (r_tap)
                    TAP_C: begin
                        w_raddr = w_center;
                        n_tap   = TAP_W;
                    end
                    TAP_W: begin
                        w_raddr = w_center - ADDR_W'(1);
                        n_tap   = TAP_E;
                    end
                    TAP_E: begin
                        w_raddr = w_center + ADDR_W'(1);
                        n_tap   = TAP_N;
                    end
                    TAP_N: begin
                        w_raddr = w_center - ADDR_W'(MAX_COLS);
                        n_tap   = TAP_S;
                    end
                    default: begin
                        w_raddr = w_center + ADDR_W'(MAX_COLS);
                        n_tap   = TAP_C;
                        if (w_sw_last_j) begin
                            n_j = COL_IDX_W'(1);
                            n_i = r_i + ROW_IDX_W'(1);
                        end else begin
                            n_j = r_j + COL_IDX_W'(1);
                        end
                    end
                endcase
            end
            ST_DRAIN: begin
                if (!i_busy) begin
                    n_i = '0;
                    n_j = '0;
                end
            end
            ST_EDGE: begin
                w_we    = 1'b1;
                w_waddr = w_center;
                w_wdata = i_cfg.boundary_value;
                if (w_edge_last) begin
                    n_cur   = ~r_cur;
                    n_steps = r_steps - STEP_W'(1);
                    n_i     = ROW_IDX_W'(1);
                    n_j     = COL_IDX_W'(1);
                    n_tap   = TAP_C;
                end else if (w_edge_last_j) begin
                    n_i = r_i + ROW_IDX_W'(1);
                    n_j = '0;
                end else if (w_edge_row) begin
                    n_j = r_j + COL_IDX_W'(1);
                end else begin
                    // interior row: jump from the left edge to the right edge
                    n_j = COL_IDX_W'(w_cols_m1);
                end
            end
            ST_DONE: begin
                w_load      = 1'b1;
                w_load_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // bank routing
    always_comb begin
        o_req_a       = '0;
        o_req_b       = '0;
        o_req_a.we    = w_we && !w_wbank;
        o_req_b.we    = w_we && w_wbank;
        o_req_a.waddr = w_waddr;
        o_req_b.waddr = w_waddr;
        o_req_a.wdata = w_wdata;
        o_req_b.wdata = w_wdata;
        o_req_a.re    = w_re && !n_rd_bank;
        o_req_b.re    = w_re && n_rd_bank;
        o_req_a.raddr = w_raddr;
        o_req_b.raddr = w_raddr;
    end

    assign o_rd_data = r_rd_bank ? i_q_b : i_q_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_tap       <= TAP_C;
            r_steps     <= '0;
            r_rd_bank   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_i       <= n_i;
            r_j       <= n_j;
            r_tap     <= n_tap;
            r_steps   <= n_steps;
            r_rd_bank <= n_rd_bank;
            r_rd_ok   <= n_rd_ok;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_load_value;
            r_out_done  <= w_load_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_done  = r_out_done;

endmodule

// ===== src/heat_diffusion_stencil_2d.sv =====
// top level of the two-bank explicit 2d heat diffusion stencil engine
//
// usage: the slave stream carries commands. tuser holds the operation (write cell,
// run, read cell); tdata holds row, column and the Q16.16 value to write. every
// command returns exactly one result transaction on the master stream: tdata is
// the cell value for a read (zero otherwise), tuser is set when a run has finished.
// registers (grid size, coefficients, step count, boundary value) are written on
// the cfg channel, which is always ready; write them only while the engine is idle.
// a cell write's result is ready in the next cycle, so writes stream one per cycle
// while the receiver takes each result; a cell read passes through the registered
// memory read before its result is loaded. during a run each interior cell needs
// five reads through the single read port of the source bank, the stencil pipeline
// drains, then the edges are written one per cycle. reset clears control state and
// selects bank a; grid contents are left undefined until written. a result waits in
// the output register while the receiver stalls, and the next command is taken in
// the same cycle it is drained.
module heat_diffusion_stencil_2d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [hds_pkg::IN_DATA_W-1:0]      i_s_tdata,   // row, col, value, zero pad
    input  logic [hds_pkg::IN_USER_W-1:0]      i_s_tuser,   // operation
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [hds_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // read_value
    output logic [hds_pkg::OUT_USER_W-1:0]     o_m_tuser,   // run_done
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hds_pkg::DATA_W-1:0]         i_cfg_data
);
    import hds_pkg::*;

    t_cfg              r_cfg;
    t_item             w_item;
    t_mem_req          w_req_a, w_req_b;
    logic [DATA_W-1:0] w_q_a, w_q_b, w_rd_data;
    t_issue            w_issue;
    t_wr               w_wr;
    logic              w_busy;
    logic              w_out_done;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows      <= RST_GRID_ROWS;
            r_cfg.grid_cols      <= RST_GRID_COLS;
            r_cfg.cx_coef        <= RST_CX_COEF;
            r_cfg.cy_coef        <= RST_CY_COEF;
            r_cfg.step_count     <= RST_STEPS;
            r_cfg.boundary_value <= RST_BOUNDARY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_ROWS: r_cfg.grid_rows      <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_COLS: r_cfg.grid_cols      <= i_cfg_data[DIM_W-1:0];
                CFG_CX_COEF:   r_cfg.cx_coef        <= i_cfg_data[COEF_W-1:0];
                CFG_CY_COEF:   r_cfg.cy_coef        <= i_cfg_data[COEF_W-1:0];
                CFG_STEPS:     r_cfg.step_count     <= i_cfg_data[STEP_W-1:0];
                CFG_BOUNDARY:  r_cfg.boundary_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // command unpacking
    assign w_item.operation = i_s_tuser;
    assign w_item.row       = i_s_tdata[ROW_W-1:0];
    assign w_item.col       = i_s_tdata[ROW_W+COL_W-1:ROW_W];
    assign w_item.value     = i_s_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

    // grid banks
    hds_ram #(
        .DEPTH (CELLS),
        .WIDTH (DATA_W)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_req_a.we),
        .i_waddr (w_req_a.waddr),
        .i_wdata (w_req_a.wdata),
        .i_re    (w_req_a.re),
        .i_raddr (w_req_a.raddr),
        .o_rdata (w_q_a)
    );

    hds_ram #(
        .DEPTH (CELLS),
        .WIDTH (DATA_W)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_req_b.we),
        .i_waddr (w_req_b.waddr),
        .i_wdata (w_req_b.wdata),
        .i_re    (w_req_b.re),
        .i_raddr (w_req_b.raddr),
        .o_rdata (w_q_b)
    );

    // stencil pipeline: reads come from one bank, results go to the other,
    // so no read-after-write hazard exists within a sweep
    hds_stencil u_stencil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cx      (r_cfg.cx_coef),
        .i_cy      (r_cfg.cy_coef),
        .i_issue   (w_issue),
        .i_rd_data (w_rd_data),
        .o_wr      (w_wr),
        .o_busy    (w_busy)
    );

    hds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (w_item),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_value (o_m_tdata),
        .o_out_done  (w_out_done),
        .i_q_a       (w_q_a),
        .i_q_b       (w_q_b),
        .o_req_a     (w_req_a),
        .o_req_b     (w_req_b),
        .o_rd_data   (w_rd_data),
        .o_issue     (w_issue),
        .i_busy      (w_busy),
        .i_wr        (w_wr)
    );

    assign o_m_tuser = w_out_done;

    // a finished run never carries a cell value
    a_done_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("run result carries a nonzero value");

    // the two banks are never written in the same cycle
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req_a.we && w_req_b.we))
        else $error("both banks written at once");

    // stencil results only appear while a run holds off new commands
    a_stencil_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.valid |-> !o_s_tready)
        else $error("stencil write while accepting commands");

    // a run command closes the command stream on the next cycle
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_RUN)) |=> !o_s_tready)
        else $error("command accepted right after a run");

endmodule
